// ----- hw/rtl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion wrappers, compiled out when ASSERT_OFF is set.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// property must hold at every clock edge outside reset
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error(msg);

`else

`define ASSERT_PROP(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, expr, msg)

`endif

`endif

// ----- hw/rtl/gspt_pkg.sv -----
// ---------------------------------------------------------------------------
// gspt_pkg
// Item types and fixed codes for the grid slot position tracker.
// ---------------------------------------------------------------------------
package gspt_pkg;

    localparam int COORD_W  = 4;
    localparam int SAMPLE_W = 10;
    localparam int ACTION_W = 2;
    localparam int DRIVE_W  = 2;
    localparam int XNUDGE_W = 2;
    localparam int MOVE_W   = 2;
    localparam int CFG_IDX_W = 1;

    // actions
    localparam logic [ACTION_W-1:0] ACT_SAMPLE = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_TARGET = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_SET_X  = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_SET_Y  = 2'd3;

    // drive commands (X: right/left, Y: up/down share the codes)
    localparam logic [DRIVE_W-1:0] DRV_STOP = 2'd0;
    localparam logic [DRIVE_W-1:0] DRV_FWD  = 2'd1;
    localparam logic [DRIVE_W-1:0] DRV_REV  = 2'd2;
    localparam logic [DRIVE_W-1:0] DRV_NONE = 2'd3;

    localparam logic [XNUDGE_W-1:0] XNUDGE_NONE  = 2'd0;
    localparam logic [XNUDGE_W-1:0] XNUDGE_RIGHT = 2'd1;
    localparam logic [XNUDGE_W-1:0] XNUDGE_LEFT  = 2'd2;

    localparam logic YNUDGE_NONE = 1'b0;
    localparam logic YNUDGE_UP   = 1'b1;

    localparam logic [MOVE_W-1:0] MV_RIGHT = 2'd0;
    localparam logic [MOVE_W-1:0] MV_LEFT  = 2'd1;
    localparam logic [MOVE_W-1:0] MV_UP    = 2'd2;
    localparam logic [MOVE_W-1:0] MV_DOWN  = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_X_THRESHOLD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_Y_THRESHOLD = 1'd1;

    localparam logic [SAMPLE_W-1:0] X_THR_RESET = 10'd50;
    localparam logic [SAMPLE_W-1:0] Y_THR_RESET = 10'd100;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [SAMPLE_W-1:0] x_sample;
        logic [SAMPLE_W-1:0] y_sample;
        logic [COORD_W-1:0]  coord_x;
        logic [COORD_W-1:0]  coord_y;
    } gspt_in_t;

    typedef struct packed {
        logic [DRIVE_W-1:0]  x_drive;
        logic [DRIVE_W-1:0]  y_drive;
        logic [XNUDGE_W-1:0] x_nudge;
        logic                y_nudge;
        logic [COORD_W-1:0]  x_now;
        logic [COORD_W-1:0]  y_now;
        logic                x_arrived;
        logic                y_arrived;
    } gspt_out_t;

endpackage

// ----- hw/rtl/gspt_core.sv -----
// ---------------------------------------------------------------------------
// gspt_core
// Tracker state and the single-pass step logic for one item.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module gspt_core
    import gspt_pkg::*;
#(
    parameter int GRID_MAX = 15
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step_en,
    input  gspt_in_t            item,
    input  logic [SAMPLE_W-1:0] x_threshold,
    input  logic [SAMPLE_W-1:0] y_threshold,
    output gspt_out_t           result
);

    localparam int POS_W = (GRID_MAX < 2) ? 1 : $clog2(GRID_MAX + 1);
    localparam int CMP_W = (POS_W > COORD_W) ? POS_W : COORD_W;
    localparam logic [CMP_W-1:0] GMAX_C = CMP_W'(GRID_MAX);
    localparam logic [POS_W-1:0] GMAX_P = POS_W'(GRID_MAX);

    logic [POS_W-1:0]   pos_x_reg, pos_x_next;
    logic [POS_W-1:0]   pos_y_reg, pos_y_next;
    logic [COORD_W-1:0] goal_x_reg, goal_x_next;
    logic [COORD_W-1:0] goal_y_reg, goal_y_next;
    logic               x_reached_reg, x_reached_next;
    logic               y_reached_reg, y_reached_next;
    logic               x_over_reg, x_over_next;
    logic               y_over_reg, y_over_next;
    logic               x_seen_reg, x_seen_next;
    logic               head_right_reg, head_right_next;
    logic               head_up_reg, head_up_next;
    logic [MOVE_W-1:0]  last_move_reg, last_move_next;

    always_comb
    begin
        logic [CMP_W-1:0]    px;
        logic [CMP_W-1:0]    py;
        logic [CMP_W-1:0]    gx;
        logic [CMP_W-1:0]    gy;
        logic [CMP_W-1:0]    cx;
        logic [CMP_W-1:0]    cy;
        logic [POS_W-1:0]    x_inc;
        logic [POS_W-1:0]    x_dec;
        logic [POS_W-1:0]    y_inc;
        logic [POS_W-1:0]    y_dec;
        logic [DRIVE_W-1:0]  xd;
        logic [DRIVE_W-1:0]  yd;
        logic [XNUDGE_W-1:0] xn;
        logic                yn;

        px = CMP_W'(pos_x_reg);
        py = CMP_W'(pos_y_reg);
        gx = CMP_W'(goal_x_reg);
        gy = CMP_W'(goal_y_reg);
        cx = CMP_W'(item.coord_x);
        cy = CMP_W'(item.coord_y);
        x_inc = (px >= GMAX_C) ? pos_x_reg : pos_x_reg + POS_W'(1);
        x_dec = (pos_x_reg == '0) ? pos_x_reg : pos_x_reg - POS_W'(1);
        y_inc = (py >= GMAX_C) ? pos_y_reg : pos_y_reg + POS_W'(1);
        y_dec = (pos_y_reg == '0) ? pos_y_reg : pos_y_reg - POS_W'(1);

        pos_x_next      = pos_x_reg;
        pos_y_next      = pos_y_reg;
        goal_x_next     = goal_x_reg;
        goal_y_next     = goal_y_reg;
        x_reached_next  = x_reached_reg;
        y_reached_next  = y_reached_reg;
        x_over_next     = x_over_reg;
        y_over_next     = y_over_reg;
        x_seen_next     = x_seen_reg;
        head_right_next = head_right_reg;
        head_up_next    = head_up_reg;
        last_move_next  = last_move_reg;
        xd = DRV_NONE;
        yd = DRV_NONE;
        xn = XNUDGE_NONE;
        yn = YNUDGE_NONE;

        case (item.action)
            ACT_SAMPLE:
            begin
                // drive commands come from the flags held before this item
                if (x_reached_reg)
                    xd = DRV_STOP;
                else
                    xd = head_right_reg ? DRV_FWD : DRV_REV;
                if (y_reached_reg)
                    yd = DRV_STOP;
                else if (x_reached_reg)
                    yd = head_up_reg ? DRV_FWD : DRV_REV;

                // X axis
                head_right_next = !(gx < px);
                x_reached_next  = (px == gx);
                if ((item.x_sample > x_threshold) && !x_reached_next)
                begin
                    if (!x_over_reg)
                    begin
                        if (head_right_next)
                        begin
                            pos_x_next     = x_inc;
                            last_move_next = MV_RIGHT;
                        end
                        else if (x_seen_reg)
                        begin
                            pos_x_next     = x_dec;
                            last_move_next = MV_LEFT;
                        end
                        if (CMP_W'(pos_x_next) == gx)
                        begin
                            xn = (last_move_next == MV_LEFT) ? XNUDGE_RIGHT : XNUDGE_LEFT;
                            x_reached_next = 1'b1;
                        end
                    end
                    x_seen_next = 1'b1;
                    x_over_next = 1'b1;
                end
                else if (!x_reached_next)
                begin
                    x_over_next = 1'b0;
                end

                // Y axis; a zero target also settles transiently at Y 1
                y_reached_next = (py == gy);
                if ((item.y_sample > y_threshold) && !y_reached_next)
                begin
                    if (!y_over_reg)
                    begin
                        if (head_up_reg)
                        begin
                            pos_y_next     = y_inc;
                            last_move_next = MV_UP;
                        end
                        else
                        begin
                            pos_y_next     = y_dec;
                            last_move_next = MV_DOWN;
                        end
                        if (CMP_W'(pos_y_next) == gy)
                        begin
                            yn = head_up_reg ? YNUDGE_NONE : YNUDGE_UP;
                            y_reached_next = 1'b1;
                        end
                        else if ((gy == '0) && (CMP_W'(pos_y_next) == CMP_W'(1)))
                        begin
                            y_reached_next = 1'b1;
                        end
                    end
                    y_over_next = 1'b1;
                end
                else if (!y_reached_next)
                begin
                    y_over_next = 1'b0;
                end
            end
            ACT_TARGET:
            begin
                goal_x_next    = item.coord_x;
                goal_y_next    = item.coord_y;
                x_reached_next = 1'b0;
                y_reached_next = 1'b0;
                x_over_next    = 1'b0;
                y_over_next    = 1'b0;
                // heading down: bump Y one slot first
                if (cy < py)
                begin
                    head_up_next = 1'b0;
                    pos_y_next   = y_inc;
                end
                else
                begin
                    head_up_next = 1'b1;
                end
            end
            ACT_SET_X:
            begin
                pos_x_next = (cx > GMAX_C) ? GMAX_P : POS_W'(cx);
            end
            ACT_SET_Y:
            begin
                pos_y_next = (cy > GMAX_C) ? GMAX_P : POS_W'(cy);
            end
            default:
            begin
                pos_x_next = pos_x_reg;
            end
        endcase

        result.x_drive   = xd;
        result.y_drive   = yd;
        result.x_nudge   = xn;
        result.y_nudge   = yn;
        result.x_now     = COORD_W'(CMP_W'(pos_x_next));
        result.y_now     = COORD_W'(CMP_W'(pos_y_next));
        result.x_arrived = x_reached_next;
        result.y_arrived = y_reached_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg      <= '0;
            pos_y_reg      <= '0;
            goal_x_reg     <= '0;
            goal_y_reg     <= '0;
            x_reached_reg  <= 1'b0;
            y_reached_reg  <= 1'b0;
            x_over_reg     <= 1'b0;
            y_over_reg     <= 1'b0;
            x_seen_reg     <= 1'b0;
            head_right_reg <= 1'b1;
            head_up_reg    <= 1'b1;
            last_move_reg  <= MV_RIGHT;
        end
        else if (step_en)
        begin
            pos_x_reg      <= pos_x_next;
            pos_y_reg      <= pos_y_next;
            goal_x_reg     <= goal_x_next;
            goal_y_reg     <= goal_y_next;
            x_reached_reg  <= x_reached_next;
            y_reached_reg  <= y_reached_next;
            x_over_reg     <= x_over_next;
            y_over_reg     <= y_over_next;
            x_seen_reg     <= x_seen_next;
            head_right_reg <= head_right_next;
            head_up_reg    <= head_up_next;
            last_move_reg  <= last_move_next;
        end
    end

    `ASSERT_NEVER(a_pos_in_grid, clk, rst_n, (pos_x_reg > GMAX_P) || (pos_y_reg > GMAX_P), "position beyond grid")
    `ASSERT_PROP(a_xnudge_arrives, clk, rst_n, (step_en && (result.x_nudge != XNUDGE_NONE)) |=> x_reached_reg, "X nudge without arrival")
    `ASSERT_PROP(a_seen_sticky, clk, rst_n, x_seen_reg |=> x_seen_reg, "slot-seen flag cleared")

endmodule

// ----- hw/rtl/grid_slot_position_tracker.sv -----
// ---------------------------------------------------------------------------
// grid_slot_position_tracker
// Two-axis gantry slot counter: sample and command items in, drive results out.
// ---------------------------------------------------------------------------
// One result item per accepted item, one item per clock sustained while out_stall
// stays low. An item is captured in the input register and worked through the step
// logic from there; on advance its result lands in the result register, where it
// can be taken. Tracker state updates as the item moves into the result register.
// out_stall reaches in_stall combinationally: the input stage stalls only while it
// is full and the result register is held.
`include "assert_macros.svh"

module grid_slot_position_tracker
    import gspt_pkg::*;
#(
    parameter int GRID_MAX = 15
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  gspt_in_t             in_item,
    output logic                 out_valid,
    input  logic                 out_stall,
    output gspt_out_t            out_item,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SAMPLE_W-1:0]  cfg_data
);

    logic                in_valid_reg, in_valid_next;
    gspt_in_t            in_item_reg;
    logic                out_valid_reg, out_valid_next;
    gspt_out_t           out_item_reg;
    logic [SAMPLE_W-1:0] x_thr_reg, x_thr_next;
    logic [SAMPLE_W-1:0] y_thr_reg, y_thr_next;
    logic                res_free;
    logic                advance;
    logic                in_take;
    gspt_out_t           step_result;

    assign res_free  = !out_valid_reg || !out_stall;
    assign advance   = in_valid_reg && res_free;
    assign in_stall  = in_valid_reg && !res_free;
    assign in_take   = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_take)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (res_free)
            out_valid_next = 1'b0;

        x_thr_next = x_thr_reg;
        y_thr_next = y_thr_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_X_THRESHOLD: x_thr_next = cfg_data;
                REG_Y_THRESHOLD: y_thr_next = cfg_data;
                default:         x_thr_next = x_thr_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            x_thr_reg     <= X_THR_RESET;
            y_thr_reg     <= Y_THR_RESET;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            x_thr_reg     <= x_thr_next;
            y_thr_reg     <= y_thr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
            in_item_reg <= in_item;
        if (advance)
            out_item_reg <= step_result;
    end

    gspt_core #(
        .GRID_MAX (GRID_MAX)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .step_en     (advance),
        .item        (in_item_reg),
        .x_threshold (x_thr_reg),
        .y_threshold (y_thr_reg),
        .result      (step_result)
    );

    `ASSERT_PROP(a_take_fills_input, clk, rst_n, in_take |=> in_valid_reg, "accepted item not held")
    `ASSERT_PROP(a_advance_fills_result, clk, rst_n, advance |=> out_valid_reg, "stepped item lost")
    `ASSERT_NEVER(a_no_overwrite, clk, rst_n, in_valid_reg && !advance && !in_stall, "input stage open while full")

endmodule

// ----- test/tb_grid_slot_position_tracker.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_grid_slot_position_tracker
// Self-checking bench for the gantry slot tracker. It runs directed items
// first, then random trips: a target followed by pulsed sensor samples. The
// trips are run under several threshold settings, with random gaps on both
// channels. A scoreboard tracks the gantry state and checks every result.
// ---------------------------------------------------------------------------
import gspt_pkg::*;

class gantry_scoreboard;
    int grid_max;
    logic [SAMPLE_W-1:0] x_thr;
    logic [SAMPLE_W-1:0] y_thr;
    logic [COORD_W-1:0]  pos_x, pos_y, goal_x, goal_y;
    bit x_reached, y_reached, x_over_slot, y_over_slot, x_slot_seen;
    bit heading_right, heading_up;
    logic [MOVE_W-1:0] last_move;
    gspt_out_t pending_reports[$];
    int mismatches, checked, samples, commands;
    int x_arrivals, y_arrivals, y_transients;

    function new(int gm);
        grid_max = gm;
        x_thr = X_THR_RESET;
        y_thr = Y_THR_RESET;
        pos_x = '0;
        pos_y = '0;
        goal_x = '0;
        goal_y = '0;
        heading_right = 1'b1;
        heading_up = 1'b1;
        last_move = MV_RIGHT;
    endfunction

    function void set_threshold(logic [CFG_IDX_W-1:0] idx, logic [SAMPLE_W-1:0] value);
        if (idx == REG_X_THRESHOLD)
            x_thr = value;
        else
            y_thr = value;
    endfunction

    function logic [COORD_W-1:0] step_up(logic [COORD_W-1:0] v);
        return (int'(v) >= grid_max) ? COORD_W'(grid_max) : v + 1'b1;
    endfunction

    function logic [COORD_W-1:0] step_down(logic [COORD_W-1:0] v);
        return (v == 0) ? v : v - 1'b1;
    endfunction

    function logic [COORD_W-1:0] clamp_pos(logic [COORD_W-1:0] v);
        return (int'(v) > grid_max) ? COORD_W'(grid_max) : v;
    endfunction

    // advance the tracked gantry by one accepted item and queue its report
    function void track_item(gspt_in_t it);
        gspt_out_t r;
        r = '0;
        r.x_drive = DRV_NONE;
        r.y_drive = DRV_NONE;
        r.x_nudge = XNUDGE_NONE;
        r.y_nudge = YNUDGE_NONE;
        case (it.action)
            ACT_SAMPLE:
            begin
                samples++;
                // drives come from the flags held before this item
                r.x_drive = x_reached ? DRV_STOP : (heading_right ? DRV_FWD : DRV_REV);
                if (y_reached)
                    r.y_drive = DRV_STOP;
                else if (x_reached)
                    r.y_drive = heading_up ? DRV_FWD : DRV_REV;

                heading_right = !(goal_x < pos_x);
                x_reached = (pos_x == goal_x);
                if (it.x_sample > x_thr && !x_reached)
                begin
                    if (!x_over_slot)
                    begin
                        if (heading_right)
                        begin
                            pos_x = step_up(pos_x);
                            last_move = MV_RIGHT;
                        end
                        else if (x_slot_seen)
                        begin
                            pos_x = step_down(pos_x);
                            last_move = MV_LEFT;
                        end
                        if (pos_x == goal_x)
                        begin
                            r.x_nudge = (last_move == MV_LEFT) ? XNUDGE_RIGHT : XNUDGE_LEFT;
                            x_reached = 1'b1;
                            x_arrivals++;
                        end
                    end
                    x_slot_seen = 1'b1;
                    x_over_slot = 1'b1;
                end
                else if (!x_reached)
                    x_over_slot = 1'b0;

                y_reached = (pos_y == goal_y);
                if (it.y_sample > y_thr && !y_reached)
                begin
                    if (!y_over_slot)
                    begin
                        if (heading_up)
                        begin
                            pos_y = step_up(pos_y);
                            last_move = MV_UP;
                        end
                        else
                        begin
                            pos_y = step_down(pos_y);
                            last_move = MV_DOWN;
                        end
                        if (pos_y == goal_y)
                        begin
                            if (!heading_up)
                                r.y_nudge = YNUDGE_UP;
                            y_reached = 1'b1;
                            y_arrivals++;
                        end
                        else if (goal_y == 0 && pos_y == 1)
                        begin
                            // passing Y 1 on the way to 0 counts as arrived, no nudge
                            y_reached = 1'b1;
                            y_transients++;
                        end
                    end
                    y_over_slot = 1'b1;
                end
                else if (!y_reached)
                    y_over_slot = 1'b0;
            end
            ACT_TARGET:
            begin
                commands++;
                goal_x = it.coord_x;
                goal_y = it.coord_y;
                x_reached = 1'b0;
                y_reached = 1'b0;
                x_over_slot = 1'b0;
                y_over_slot = 1'b0;
                if (goal_y < pos_y)
                begin
                    heading_up = 1'b0;
                    pos_y = step_up(pos_y);
                end
                else
                    heading_up = 1'b1;
            end
            ACT_SET_X:
            begin
                commands++;
                pos_x = clamp_pos(it.coord_x);
            end
            default:
            begin
                commands++;
                pos_y = clamp_pos(it.coord_y);
            end
        endcase
        r.x_now = pos_x;
        r.y_now = pos_y;
        r.x_arrived = x_reached;
        r.y_arrived = y_reached;
        pending_reports.push_back(r);
    endfunction

    function void compare_field(string name, logic [3:0] expv, logic [3:0] gotv);
        if (gotv !== expv)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("result %0d: %s expected %0d, got %0d", checked, name, expv, gotv);
        end
    endfunction

    function void check_result(gspt_out_t got);
        gspt_out_t want;
        if (pending_reports.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result item: %p", got);
            return;
        end
        want = pending_reports.pop_front();
        compare_field("x_drive", want.x_drive, got.x_drive);
        compare_field("y_drive", want.y_drive, got.y_drive);
        compare_field("x_nudge", want.x_nudge, got.x_nudge);
        compare_field("y_nudge", want.y_nudge, got.y_nudge);
        compare_field("x_now", want.x_now, got.x_now);
        compare_field("y_now", want.y_now, got.y_now);
        compare_field("x_arrived", want.x_arrived, got.x_arrived);
        compare_field("y_arrived", want.y_arrived, got.y_arrived);
        checked++;
    endfunction
endclass

module tb_grid_slot_position_tracker;

    localparam int GRID_MAX = 15;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASES = 8;
    localparam int PHASE_ITEMS = 210;

    logic                 clk;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    gspt_in_t             in_item = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    gspt_out_t            out_item;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = REG_X_THRESHOLD;
    logic [SAMPLE_W-1:0]  cfg_data = '0;

    gantry_scoreboard sb = new(GRID_MAX);
    bit gaps_on = 1'b0;
    int items_sent = 0;
    int settings = 0;
    int cycles = 0;
    int x_thr_now = X_THR_RESET;
    int y_thr_now = Y_THR_RESET;

    grid_slot_position_tracker #(
        .GRID_MAX (GRID_MAX)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d reports outstanding",
                     cycles, sb.pending_reports.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
            sb.check_result(out_item);
    end

    // result side back-pressure in bursts
    initial
    begin
        int burst;
        burst = 0;
        forever
        begin
            @(negedge clk);
            if (burst > 0)
            begin
                out_stall = 1'b1;
                burst--;
            end
            else if (gaps_on && $urandom_range(0, 9) == 0)
            begin
                out_stall = 1'b1;
                burst = $urandom_range(1, 14) - 1;
            end
            else
                out_stall = 1'b0;
        end
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_item(input gspt_in_t it);
        int gap;
        if (gaps_on && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 14);
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        in_item = it;
        do
            @(posedge clk);
        while (in_stall);
        sb.track_item(it);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic drive(input logic [ACTION_W-1:0] act, input int xs, input int ys,
                         input int cx, input int cy);
        gspt_in_t it;
        it.action = act;
        it.x_sample = SAMPLE_W'(xs);
        it.y_sample = SAMPLE_W'(ys);
        it.coord_x = COORD_W'(cx);
        it.coord_y = COORD_W'(cy);
        send_item(it);
    endtask

    task automatic write_threshold(input logic [CFG_IDX_W-1:0] idx, input int value);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = SAMPLE_W'(value);
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.set_threshold(idx, cfg_data);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // thresholds only change once every outstanding result has drained
    task automatic apply_thresholds(input int xt, input int yt);
        in_valid = 1'b0;
        while (sb.pending_reports.size() != 0)
            @(negedge clk);
        write_threshold(REG_X_THRESHOLD, xt);
        write_threshold(REG_Y_THRESHOLD, yt);
        x_thr_now = xt;
        y_thr_now = yt;
        settings++;
    endtask

    function automatic logic [SAMPLE_W-1:0] sensor_level(bit above, int thr);
        if (!above)
            return SAMPLE_W'($urandom_range(0, thr));
        if (thr >= 1023)
            return 10'h3FF;
        return SAMPLE_W'($urandom_range(thr + 1, 1023));
    endfunction

    function automatic gspt_in_t random_item();
        gspt_in_t it;
        it.action = ACTION_W'($urandom_range(0, 3));
        it.x_sample = SAMPLE_W'($urandom_range(0, 1023));
        it.y_sample = SAMPLE_W'($urandom_range(0, 1023));
        it.coord_x = COORD_W'($urandom_range(0, 15));
        it.coord_y = COORD_W'($urandom_range(0, 15));
        return it;
    endfunction

    // optional position sets, then a target followed by pulsed sensor samples, with some noise mixed in
    task automatic run_trip();
        gspt_in_t it;
        int n;
        bit x_hi, y_hi;
        int x_run, y_run;
        if ($urandom_range(0, 2) == 0)
        begin
            it = random_item();
            it.action = ACT_SET_X;
            send_item(it);
        end
        if ($urandom_range(0, 2) == 0)
        begin
            it = random_item();
            it.action = ACT_SET_Y;
            send_item(it);
        end
        it = random_item();
        it.action = ACT_TARGET;
        if ($urandom_range(0, 4) == 0)
            it.coord_y = '0;
        send_item(it);
        n = $urandom_range(8, 40);
        x_hi = 1'b0;
        y_hi = 1'b0;
        x_run = $urandom_range(1, 3);
        y_run = $urandom_range(1, 3);
        repeat (n)
        begin
            it = random_item();
            if ($urandom_range(0, 6) != 0)
            begin
                x_run--;
                if (x_run <= 0)
                begin
                    x_hi = !x_hi;
                    x_run = $urandom_range(1, 3);
                end
                y_run--;
                if (y_run <= 0)
                begin
                    y_hi = !y_hi;
                    y_run = $urandom_range(1, 3);
                end
                it.action = ACT_SAMPLE;
                it.x_sample = sensor_level(x_hi, x_thr_now);
                it.y_sample = sensor_level(y_hi, y_thr_now);
            end
            send_item(it);
        end
    endtask

    initial
    begin
        int xt, yt;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed, reset thresholds: left move before any slot seen comes first
        drive(ACT_SAMPLE, 0, 0, 0, 0);
        drive(ACT_SET_X, 0, 0, 5, 9);
        drive(ACT_TARGET, 0, 0, 2, 0);
        drive(ACT_SAMPLE, 1023, 0, 0, 0);
        drive(ACT_SAMPLE, 0, 0, 0, 0);
        drive(ACT_SAMPLE, 1023, 0, 0, 0);
        drive(ACT_SAMPLE, 50, 0, 0, 0);
        drive(ACT_SAMPLE, 51, 0, 0, 0);
        drive(ACT_SAMPLE, 0, 0, 0, 0);
        drive(ACT_SAMPLE, 51, 0, 0, 0);
        // Y target below position: bump, count down, transient stop at 1
        drive(ACT_SET_Y, 0, 0, 6, 2);
        drive(ACT_TARGET, 0, 0, 2, 0);
        drive(ACT_SAMPLE, 0, 1023, 0, 0);
        drive(ACT_SAMPLE, 0, 100, 0, 0);
        drive(ACT_SAMPLE, 0, 101, 0, 0);
        drive(ACT_SAMPLE, 0, 0, 0, 0);
        drive(ACT_SAMPLE, 0, 1023, 0, 0);
        // top corner and saturation
        drive(ACT_SET_X, 0, 0, 14, 0);
        drive(ACT_SET_Y, 0, 0, 0, 14);
        drive(ACT_TARGET, 0, 0, 15, 15);
        drive(ACT_SAMPLE, 1023, 1023, 0, 0);
        drive(ACT_SAMPLE, 1023, 1023, 15, 15);
        drive(ACT_SET_X, 1023, 1023, 15, 15);
        drive(ACT_SET_Y, 1023, 1023, 15, 15);
        drive(ACT_TARGET, 1023, 1023, 0, 0);
        drive(ACT_SAMPLE, 1023, 1023, 15, 15);

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0: begin xt = 0;    yt = 0;    end
                1: begin xt = 1023; yt = 1023; end
                2: begin xt = 1023; yt = 0;    end
                3: begin xt = 0;    yt = 1023; end
                default:
                begin
                    xt = $urandom_range(0, 1023);
                    yt = $urandom_range(0, 1023);
                end
            endcase
            apply_thresholds(xt, yt);
            while (items_sent < 26 + (p + 1) * PHASE_ITEMS)
            begin
                // quiet stretches now and then; none at all in the last phase
                gaps_on = (p != PHASES - 1) && ($urandom_range(0, 4) != 0);
                run_trip();
            end
        end
        in_valid = 1'b0;
        gaps_on = 1'b0;

        while (sb.pending_reports.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);

        if (sb.pending_reports.size() != 0)
            sb.mismatches += sb.pending_reports.size();
        $display("%0d items (%0d samples, %0d commands) under %0d threshold settings",
                 items_sent, sb.samples, sb.commands, settings + 1);
        $display("%0d results checked; X arrivals %0d, Y arrivals %0d, transient Y %0d",
                 sb.checked, sb.x_arrivals, sb.y_arrivals, sb.y_transients);
        if (sb.mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
